// ----- sv/arrival_sorted_job_queue_defines.svh -----
// Assertion macros for the arrival-sorted job queue checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef ARRIVAL_SORTED_JOB_QUEUE_DEFINES_SVH
`define ARRIVAL_SORTED_JOB_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AJQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AJQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ajq_pkg.sv -----
// Shared types and constants for the arrival-sorted job queue.
// No dependencies; imported by every module of the block.
package ajq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int ID_W            = 16;
    localparam int TIME_W          = 32;
    localparam int CNT_OUT_W       = 7;

    // Request codes carried in the req_type field.
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_PEEK   = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One queue entry.
    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] duration;
    } entry_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic load_cmp;
        logic commit;
        req_t op;
    } cell_ctrl_t;

endpackage

// ----- sv/ajq_cell.sv -----
// One cell of the queue: holds a single entry and its sort-compare flag.
// Depends on ajq_pkg.
module ajq_cell
    import ajq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CELL_INDEX  = 0
)
(
    input  logic                                 clk,
    input  cell_ctrl_t                           ctrl,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     count,
    input  logic [TIME_W-1:0]                    cmp_key,
    input  entry_t                               new_entry,
    input  entry_t                               left_entry,
    input  entry_t                               right_entry,
    input  logic                                 found_in,
    output logic                                 found_out,
    output entry_t                               entry
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   gt_reg;
    logic   occupied;
    logic   at_tail;
    logic   upto_tail;

    // Position of this cell relative to the current tail.
    assign occupied  = count > MY_INDEX;
    assign at_tail   = count == MY_INDEX;
    assign upto_tail = count >= MY_INDEX;

    // A later arrival in this cell or anywhere to the left has already claimed the insert slot.
    assign found_out = found_in | gt_reg;
    assign entry     = entry_reg;

    // Next contents of the cell for each kind of request.
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            REQ_APPEND:
            begin
                if (at_tail)
                begin
                    entry_next = new_entry;
                end
            end
            REQ_INSERT:
            begin
                if (found_in && upto_tail)
                begin
                    entry_next = left_entry;
                end
                else if (!found_in && (gt_reg || at_tail))
                begin
                    entry_next = new_entry;
                end
            end
            REQ_REMOVE:
            begin
                entry_next = right_entry;
            end
            REQ_PEEK:
            begin
                entry_next = entry_reg;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // The compare flag is captured when the word is accepted; the entry
    // changes when the request is committed.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_cmp)
        begin
            gt_reg <= occupied && (entry_reg.arrival > cmp_key);
        end
        if (ctrl.commit)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ----- sv/ajq_chain.sv -----
// Row of queue cells, each linked to its left and right neighbour.
// Depends on ajq_pkg and ajq_cell.
module ajq_chain
    import ajq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                                 clk,
    input  cell_ctrl_t                           ctrl,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     count,
    input  logic [TIME_W-1:0]                    cmp_key,
    input  entry_t                               new_entry,
    output entry_t                               head
);

    entry_t cell_entry [QUEUE_DEPTH];
    entry_t left_in    [QUEUE_DEPTH];
    entry_t right_in   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] found;

    assign found[0] = 1'b0;
    assign head     = cell_entry[0];

    // Build the row; the ends see an empty left neighbour and themselves.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_in[i] = '0;
        end
        else
        begin : g_inner_left
            assign left_in[i] = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH-1)
        begin : g_last
            assign right_in[i] = cell_entry[i];
        end
        else
        begin : g_inner_right
            assign right_in[i] = cell_entry[i+1];
        end

        ajq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .CELL_INDEX  (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count),
            .cmp_key     (cmp_key),
            .new_entry   (new_entry),
            .left_entry  (left_in[i]),
            .right_entry (right_in[i]),
            .found_in    (found[i]),
            .found_out   (found[i+1]),
            .entry       (cell_entry[i])
        );
    end

endmodule

// ----- sv/arrival_sorted_job_queue.sv -----
// Arrival-sorted job queue: append, sorted insert, remove head, peek head.
// An accepted word is held in the request registers until it completes and its
// result word is registered. One word is in flight at a time; every cell compares
// its arrival time against the new key on the accept edge and shifts on commit.
// Reset clears the entry count and the handshake state; cell contents are
// left as they are and only ever read below the count.
module arrival_sorted_job_queue
    import ajq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            req_type,
    input  logic [ID_W-1:0]       job_id,
    input  logic [TIME_W-1:0]     arrival_time,
    input  logic [TIME_W-1:0]     duration,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [1:0]            status,
    output logic                  out_valid,
    output logic [ID_W-1:0]       out_job_id,
    output logic [TIME_W-1:0]     out_arrival_time,
    output logic [TIME_W-1:0]     out_duration,
    output logic [CNT_OUT_W-1:0]  entry_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    logic                 busy_reg;
    logic                 rsp_valid_reg;
    logic [CNT_W-1:0]     held_count_reg;
    logic [CNT_W-1:0]     held_count_next;
    req_t                 op_reg;
    entry_t               new_entry_reg;
    entry_t               head;
    cell_ctrl_t           ctrl;
    logic                 accept;
    logic                 done;
    logic                 full;
    logic                 empty;
    logic                 success;
    status_t              status_next;
    logic                 out_valid_next;
    logic [CNT_W+CNT_OUT_W-1:0] count_wide;

    logic [1:0]           status_reg;
    logic                 out_valid_reg;
    entry_t               out_entry_reg;
    logic [CNT_OUT_W-1:0] entry_count_reg;

    // Handshake: one word in flight; it completes once the result register is free.
    assign accept    = req_valid && !busy_reg;
    assign done      = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = busy_reg;
    assign full      = held_count_reg == FULL_COUNT;
    assign empty     = held_count_reg == '0;

    // Outcome of the pending request.
    always_comb
    begin
        status_next     = ST_OK;
        out_valid_next  = 1'b0;
        success         = 1'b0;
        held_count_next = held_count_reg;
        case (op_reg)
            REQ_APPEND, REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    success         = 1'b1;
                    held_count_next = held_count_reg + 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    success         = 1'b1;
                    out_valid_next  = 1'b1;
                    held_count_next = held_count_reg - 1'b1;
                end
            end
            REQ_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Control broadcast to the cells.
    assign ctrl.load_cmp = accept;
    assign ctrl.commit   = done && success;
    assign ctrl.op       = op_reg;

    ajq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (held_count_reg),
        .cmp_key   (arrival_time),
        .new_entry (new_entry_reg),
        .head      (head)
    );

    assign count_wide = {{CNT_OUT_W{1'b0}}, held_count_next};

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            held_count_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end

            if (done)
            begin
                rsp_valid_reg  <= 1'b1;
                held_count_reg <= held_count_next;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg                 <= req_t'(req_type);
            new_entry_reg.job_id   <= job_id;
            new_entry_reg.arrival  <= arrival_time;
            new_entry_reg.duration <= duration;
        end
        if (done)
        begin
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
            out_entry_reg   <= out_valid_next ? head : '0;
            entry_count_reg <= count_wide[CNT_OUT_W-1:0];
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign out_valid        = out_valid_reg;
    assign out_job_id       = out_entry_reg.job_id;
    assign out_arrival_time = out_entry_reg.arrival;
    assign out_duration     = out_entry_reg.duration;
    assign entry_count      = entry_count_reg;

endmodule

// ----- sv/ajq_checker.sv -----
// Port-level checks for the arrival-sorted job queue, bound to the top level.
// Depends on ajq_pkg and arrival_sorted_job_queue_defines.svh.
`include "arrival_sorted_job_queue_defines.svh"

module ajq_checker
    import ajq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_stall,
    input logic                  rsp_valid,
    input logic                  rsp_stall,
    input logic [1:0]            status,
    input logic                  out_valid,
    input logic [CNT_OUT_W-1:0]  entry_count
);

    // A result word waiting on a stalled receiver stays offered.
    `AJQ_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")

    // Only one word is in flight: an accepted word stalls the input.
    `AJQ_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "input not stalled after accept")

    // A returned entry only comes with a success status.
    `AJQ_ASSERT_SAME(a_entry_ok, rsp_valid && out_valid, status == ST_OK, "entry returned with error status")

    // An empty report means the queue really holds nothing.
    `AJQ_ASSERT_SAME(a_empty_count, rsp_valid && (status == ST_EMPTY), (entry_count == '0) && !out_valid, "empty status with entries held")

endmodule

bind arrival_sorted_job_queue ajq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ajq_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for the arrival-sorted job queue.
// Depends on ajq_pkg and the arrival_sorted_job_queue module; reads no files.
module testbench;
    import ajq_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int RANDOM_WORDS = 2000;
    localparam int QUIET_TAIL  = 150;
    localparam int IDLE_LIMIT  = 4000;

    // One request word as it is driven into the block.
    typedef struct {
        req_t                op;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   arrival;
        logic [TIME_W-1:0]   dur;
    } request_word_t;

    // One result word as the block should return it.
    typedef struct {
        status_t               status;
        logic                  hit;
        logic [ID_W-1:0]       id;
        logic [TIME_W-1:0]     arrival;
        logic [TIME_W-1:0]     dur;
        logic [CNT_OUT_W-1:0]  count;
    } result_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [1:0]            req_type = 2'd0;
    logic [ID_W-1:0]       job_id = '0;
    logic [TIME_W-1:0]     arrival_time = '0;
    logic [TIME_W-1:0]     duration = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic [1:0]            status;
    logic                  out_valid;
    logic [ID_W-1:0]       out_job_id;
    logic [TIME_W-1:0]     out_arrival_time;
    logic [TIME_W-1:0]     out_duration;
    logic [CNT_OUT_W-1:0]  entry_count;

    request_word_t pending_words[$];
    result_word_t  awaited_results[$];
    entry_t        job_line[$];
    int            fault_count = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            idle_cycles = 0;

    arrival_sorted_job_queue dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req_type         (req_type),
        .job_id           (job_id),
        .arrival_time     (arrival_time),
        .duration         (duration),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .out_valid        (out_valid),
        .out_job_id       (out_job_id),
        .out_arrival_time (out_arrival_time),
        .out_duration     (out_duration),
        .entry_count      (entry_count)
    );

    always #6 clk = ~clk;

    // Applies one request to the local copy of the queue and returns the result word.
    function automatic result_word_t apply_request(request_word_t w);
        result_word_t r;
        entry_t       e;
        int           pos;
        r = '{status: ST_OK, hit: 1'b0, id: '0, arrival: '0, dur: '0, count: '0};
        if (w.op == REQ_APPEND || w.op == REQ_INSERT) begin
            if (job_line.size() >= DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                e.job_id   = w.id;
                e.arrival  = w.arrival;
                e.duration = w.dur;
                pos = job_line.size();
                // A sorted insert goes ahead of the first strictly later arrival only.
                if (w.op == REQ_INSERT) begin
                    for (int i = job_line.size() - 1; i >= 0; i--) begin
                        if (job_line[i].arrival > w.arrival)
                            pos = i;
                    end
                end
                job_line.insert(pos, e);
            end
        end
        else if (job_line.size() == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            r.hit     = 1'b1;
            r.id      = job_line[0].job_id;
            r.arrival = job_line[0].arrival;
            r.dur     = job_line[0].duration;
            if (w.op == REQ_REMOVE)
                void'(job_line.pop_front());
        end
        r.count = CNT_OUT_W'(job_line.size());
        return r;
    endfunction

    task automatic add_word(req_t op, int unsigned id, logic [TIME_W-1:0] arrival,
                            logic [TIME_W-1:0] dur);
        request_word_t w;
        w.op      = op;
        w.id      = ID_W'(id);
        w.arrival = arrival;
        w.dur     = dur;
        pending_words.push_back(w);
    endtask

    // Arrival times favour a small range so that ties are common.
    function automatic logic [TIME_W-1:0] pick_arrival();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 15);
            5, 6:          return $urandom;
            7:             return '0;
            8:             return '1;
            default:       return 32'hFFFF_FFF0 + $urandom_range(0, 15);
        endcase
    endfunction

    // Stimulus: a directed opening, then runs biased to fill, drain or mix.
    initial begin
        int mode;
        int run_len;
        int made;
        req_t op;

        // Remove and peek on an empty queue.
        add_word(REQ_PEEK,   16'hFFFF, '1, '1);
        add_word(REQ_REMOVE, 16'h0000, '0, '0);
        // Extremes of every field, then sorted inserts with equal arrival times.
        add_word(REQ_APPEND, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        add_word(REQ_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_word(REQ_INSERT, 16'h0005, 32'd5, 32'h5555_5555);
        add_word(REQ_INSERT, 16'h0105, 32'd5, 32'hAAAA_AAAA);
        add_word(REQ_INSERT, 16'h0200, 32'd0, 32'h1234_5678);
        add_word(REQ_INSERT, 16'h0300, 32'hFFFF_FFFF, 32'h8765_4321);
        add_word(REQ_INSERT, 16'hAAAA, 32'h8000_0000, 32'h0000_0001);
        add_word(REQ_PEEK,   16'h5555, 32'h5555_5555, 32'hAAAA_AAAA);
        for (int i = 0; i < 8; i++)
            add_word(REQ_REMOVE, 16'h0000, '0, '0);
        add_word(REQ_PEEK,   16'h0000, '0, '0);
        add_word(REQ_INSERT, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
        add_word(REQ_PEEK,   16'h0000, '0, '0);
        add_word(REQ_REMOVE, 16'h0000, '0, '0);

        // Fill-biased runs reach a full queue, drain-biased runs an empty one.
        made = 0;
        while (made < RANDOM_WORDS) begin
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(20, 120);
            for (int i = 0; i < run_len && made < RANDOM_WORDS; i++) begin
                int pct;
                pct = $urandom_range(0, 99);
                if ((mode == 0 && pct < 85) || (mode == 1 && pct < 15) ||
                    (mode == 2 && pct < 50))
                    op = ($urandom_range(0, 1) != 0) ? REQ_INSERT : REQ_APPEND;
                else
                    op = ($urandom_range(0, 3) != 0) ? REQ_REMOVE : REQ_PEEK;
                add_word(op, $urandom_range(0, 65535), pick_arrival(), $urandom);
                made++;
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || req_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Request driver: holds a stalled word, otherwise idles in bursts or sends the next.
    always @(posedge clk) begin
        request_word_t w;
        if (!rst_n) begin
            req_valid <= 1'b0;
            send_gap  <= 0;
        end
        else if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
                send_gap  <= send_gap - 1;
                req_valid <= 1'b0;
            end
            else if (pending_words.size() == 0) begin
                req_valid <= 1'b0;
            end
            else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                send_gap  <= $urandom_range(1, 18) - 1;
                req_valid <= 1'b0;
            end
            else begin
                w = pending_words.pop_front();
                req_valid    <= 1'b1;
                req_type     <= w.op;
                job_id       <= w.id;
                arrival_time <= w.arrival;
                duration     <= w.dur;
            end
        end
    end

    // Result stall: random bursts, none once the tail of the stimulus is reached.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            rsp_stall  <= 1'b1;
        end
        else begin
            rsp_stall <= 1'b0;
        end
    end

    // Monitor: checks each accepted result word, then predicts each accepted request.
    always @(posedge clk) begin
        result_word_t want;
        request_word_t w;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: unexpected result word: status %0d count %0d",
                             $realtime, status, entry_count);
            end
            else begin
                want = awaited_results.pop_front();
                if (status !== want.status || out_valid !== want.hit ||
                    out_job_id !== want.id || out_arrival_time !== want.arrival ||
                    out_duration !== want.dur || entry_count !== want.count) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("%0t: mismatch: exp st %0d ov %0d id %h arr %h dur %h cnt %0d",
                                 $realtime, want.status, want.hit, want.id, want.arrival,
                                 want.dur, want.count);
                        $display("%0t:           got st %0d ov %0d id %h arr %h dur %h cnt %0d",
                                 $realtime, status, out_valid, out_job_id,
                                 out_arrival_time, out_duration, entry_count);
                    end
                end
            end
        end
        if (rst_n && req_valid && !req_stall) begin
            w.op      = req_t'(req_type);
            w.id      = job_id;
            w.arrival = arrival_time;
            w.dur     = duration;
            awaited_results.push_back(apply_request(w));
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
